[src/ctt_pkg.sv]
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants for the configuration text tokenizer
// Result record, push bundle, scanner states, token kinds, error codes,
// character constants and saturating counter helpers.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  // token kinds
  localparam logic [3:0] KIND_EOF    = 4'd0;
  localparam logic [3:0] KIND_LBRACK = 4'd1;
  localparam logic [3:0] KIND_RBRACK = 4'd2;
  localparam logic [3:0] KIND_LBRACE = 4'd3;
  localparam logic [3:0] KIND_RBRACE = 4'd4;
  localparam logic [3:0] KIND_IDENT  = 4'd5;
  localparam logic [3:0] KIND_INT    = 4'd6;
  localparam logic [3:0] KIND_FLOAT  = 4'd7;
  localparam logic [3:0] KIND_TRUE   = 4'd8;
  localparam logic [3:0] KIND_FALSE  = 4'd9;
  localparam logic [3:0] KIND_STRING = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BOOL    = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_Y      = 8'h79;
  localparam logic [7:0] CH_N      = 8'h6E;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDENT,
    S_INT,
    S_DOT,
    S_FLOAT,
    S_QMARK,
    S_STRING,
    S_COMMENT
  } scan_state_t;

  typedef struct packed {
    logic [3:0]             kind;
    logic [1:0]             err;
    logic [7:0]             bad;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } ctt_result_t;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0]                        count;
    ctt_result_t [MAX_RESULTS-1:0]     item;
  } ctt_push_t;

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic [3:0] bracket_kind(input logic [7:0] c);
    logic [3:0] k;
    k = KIND_RBRACE;
    if (c == CH_LBRACK) k = KIND_LBRACK;
    else if (c == CH_RBRACK) k = KIND_RBRACK;
    else if (c == CH_LBRACE) k = KIND_LBRACE;
    return k;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] a);
    return (a == OFF_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] a);
    return (a == LINE_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] a);
    return (a == COL_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [1:0] d);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + {{(LENGTH_BITS-1){1'b0}}, d};
    return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  // position just past the open token, for a dot with no digit after it
  function automatic logic [OFFSET_BITS-1:0] off_add_len(input logic [OFFSET_BITS-1:0] a,
                                                          input logic [LENGTH_BITS-1:0] l);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + {{(OFFSET_BITS+1-LENGTH_BITS){1'b0}}, l};
    return (s > {1'b0, OFF_MAX}) ? OFF_MAX : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_add_len(input logic [COLUMN_BITS-1:0] a,
                                                          input logic [LENGTH_BITS-1:0] l);
    logic [COLUMN_BITS:0] s;
    s = {1'b0, a} + {1'b0, l};
    return (s > {1'b0, COL_MAX}) ? COL_MAX : s[COLUMN_BITS-1:0];
  endfunction

  function automatic ctt_result_t mk_res(input logic [3:0] kind, input logic [1:0] err,
                                         input logic [7:0] bad,
                                         input logic [OFFSET_BITS-1:0] start,
                                         input logic [LENGTH_BITS-1:0] len,
                                         input logic [LINE_BITS-1:0] line,
                                         input logic [COLUMN_BITS-1:0] col,
                                         input logic last);
    ctt_result_t r;
    r.kind  = kind;
    r.err   = err;
    r.bad   = bad;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.col   = col;
    r.last  = last;
    return r;
  endfunction

endpackage

[src/config_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// config_text_tokenizer: streaming tokenizer for configuration text
// Path: an accepted byte is held in the scanner's stage register, scanned once
// the result queue has room, and its results are written into that queue.
// Throughput: one byte per cycle while the result queue has room, set by the
// single scanner step per byte; the output channel presents results one at a time.
// Reset: synchronous rst clears scanner state and empties the result queue.
// ----------------------------------------------------------------------------
module config_text_tokenizer
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [1:0]  error_code,
  output logic [7:0]  bad_char,
  output logic [23:0] start_offset,
  output logic [15:0] token_length,
  output logic [19:0] line_number,
  output logic [15:0] column_number,
  output logic        stream_end
);

  ctt_push_t   push;
  ctt_result_t head;
  logic        space_ok;

  ctt_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .space_ok   (space_ok),
    .push       (push)
  );

  ctt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign token_kind    = head.kind;
  assign error_code    = head.err;
  assign bad_char      = head.bad;
  assign start_offset  = head.start;
  assign token_length  = head.len;
  assign line_number   = head.line;
  assign column_number = head.col;
  assign stream_end    = head.last;

endmodule

[src/ctt_scanner.sv]
// ----------------------------------------------------------------------------
// ctt_scanner: byte scanner
// Registers the incoming byte, then runs one scanner step per byte and hands
// up to three results to the result queue in the same cycle.
// ----------------------------------------------------------------------------
module ctt_scanner
  import ctt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  input  logic       space_ok,
  output ctt_push_t  push
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_final;
  logic       advance;

  scan_state_t            scan_state, scan_state_next;
  logic                   halted, halted_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0] cur_column, cur_column_next;
  logic [OFFSET_BITS-1:0] tok_start, tok_start_next;
  logic [LENGTH_BITS-1:0] tok_length, tok_length_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0] tok_column, tok_column_next;

  assign advance  = stage_valid && space_ok;
  assign in_ready = !stage_valid || space_ok;

  always_comb begin : step
    logic [1:0]    n;
    logic          pass;
    logic          stop;
    logic [7:0]    b;
    ctt_result_t [MAX_RESULTS-1:0] items;

    n     = 2'd0;
    pass  = 1'b0;
    stop  = 1'b0;
    b     = stage_byte;
    items = '0;

    scan_state_next  = scan_state;
    halted_next      = halted;
    byte_offset_next = byte_offset;
    cur_line_next    = cur_line;
    cur_column_next  = cur_column;
    tok_start_next   = tok_start;
    tok_length_next  = tok_length;
    tok_line_next    = tok_line;
    tok_column_next  = tok_column;

    if (advance && !halted) begin
      if (b != CH_NUL) begin
        case (scan_state)
          S_IDENT: begin
            if (word_char(b) || digit_char(b)) begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              cur_column_next = col_inc(cur_column_next);
            end else begin
              items[n] = mk_res(KIND_IDENT, ERR_NONE, 8'd0, tok_start_next,
                                tok_length_next, cur_line_next, tok_column_next, 1'b0);
              n = n + 2'd1;
              pass = 1'b1;
            end
          end
          S_INT: begin
            if (digit_char(b)) begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              cur_column_next = col_inc(cur_column_next);
            end else if (b == CH_DOT) begin
              scan_state_next = S_DOT;
              cur_column_next = col_inc(cur_column_next);
            end else begin
              items[n] = mk_res(KIND_INT, ERR_NONE, 8'd0, tok_start_next,
                                tok_length_next, cur_line_next, tok_column_next, 1'b0);
              n = n + 2'd1;
              pass = 1'b1;
            end
          end
          S_DOT: begin
            if (!digit_char(b)) begin
              items[n] = mk_res(KIND_INT, ERR_NONE, 8'd0, tok_start_next,
                                tok_length_next, cur_line_next, tok_column_next, 1'b0);
              n = n + 2'd1;
              items[n] = mk_res(KIND_EOF, ERR_UNKNOWN, CH_DOT,
                                off_add_len(tok_start_next, tok_length_next), '0,
                                cur_line_next, col_add_len(tok_column_next, tok_length_next),
                                1'b1);
              n = n + 2'd1;
              halted_next     = 1'b1;
              scan_state_next = S_IDLE;
              stop = 1'b1;
            end else begin
              tok_length_next = len_add(tok_length_next, 2'd2);
              cur_column_next = col_inc(cur_column_next);
              scan_state_next = S_FLOAT;
            end
          end
          S_FLOAT: begin
            if (digit_char(b)) begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              cur_column_next = col_inc(cur_column_next);
            end else begin
              items[n] = mk_res(KIND_FLOAT, ERR_NONE, 8'd0, tok_start_next,
                                tok_length_next, cur_line_next, tok_column_next, 1'b0);
              n = n + 2'd1;
              pass = 1'b1;
            end
          end
          S_QMARK: begin
            if (b == CH_SPACE) begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              cur_column_next = col_inc(cur_column_next);
            end else if (b == CH_Y || b == CH_N) begin
              tok_length_next = len_add(tok_length_next, 2'd1);
              cur_column_next = col_inc(cur_column_next);
              items[n] = mk_res((b == CH_Y) ? KIND_TRUE : KIND_FALSE, ERR_NONE, 8'd0,
                                tok_start_next, tok_length_next, cur_line_next,
                                tok_column_next, 1'b0);
              n = n + 2'd1;
              scan_state_next = S_IDLE;
            end else begin
              items[n] = mk_res(KIND_EOF, ERR_BOOL, 8'd0, tok_start_next, '0,
                                tok_line_next, tok_column_next, 1'b1);
              n = n + 2'd1;
              halted_next     = 1'b1;
              scan_state_next = S_IDLE;
              stop = 1'b1;
            end
          end
          S_STRING: begin
            tok_length_next = len_add(tok_length_next, 2'd1);
            cur_column_next = col_inc(cur_column_next);
            if (b == CH_QUOTE) begin
              items[n] = mk_res(KIND_STRING, ERR_NONE, 8'd0, tok_start_next,
                                tok_length_next, cur_line_next, tok_column_next, 1'b0);
              n = n + 2'd1;
              scan_state_next = S_IDLE;
            end else if (b == CH_LF) begin
              cur_line_next = line_inc(cur_line_next);
            end
          end
          S_COMMENT: begin
            if (b == CH_LF) begin
              cur_line_next   = line_inc(cur_line_next);
              cur_column_next = '0 + 1'b1;
              scan_state_next = S_IDLE;
            end
          end
          default: pass = 1'b1;
        endcase

        // the byte that closed a token, or any byte with no token open
        if (pass) begin
          scan_state_next = S_IDLE;
          if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
            cur_column_next = col_inc(cur_column_next);
          end else if (b == CH_LF) begin
            cur_line_next   = line_inc(cur_line_next);
            cur_column_next = '0 + 1'b1;
          end else if (b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE ||
                       b == CH_RBRACE) begin
            items[n] = mk_res(bracket_kind(b), ERR_NONE, 8'd0, byte_offset_next,
                              '0 + 1'b1, cur_line_next, cur_column_next, 1'b0);
            n = n + 2'd1;
            cur_column_next = col_inc(cur_column_next);
          end else if (b == CH_QMARK || b == CH_QUOTE || digit_char(b) || word_char(b)) begin
            if (b == CH_QMARK) scan_state_next = S_QMARK;
            else if (b == CH_QUOTE) scan_state_next = S_STRING;
            else if (digit_char(b)) scan_state_next = S_INT;
            else scan_state_next = S_IDENT;
            tok_start_next  = byte_offset_next;
            tok_length_next = '0 + 1'b1;
            tok_line_next   = cur_line_next;
            tok_column_next = cur_column_next;
            cur_column_next = col_inc(cur_column_next);
          end else if (b == CH_HASH) begin
            scan_state_next = S_COMMENT;
          end else begin
            items[n] = mk_res(KIND_EOF, ERR_UNKNOWN, b, byte_offset_next, '0,
                              cur_line_next, cur_column_next, 1'b1);
            n = n + 2'd1;
            halted_next     = 1'b1;
            scan_state_next = S_IDLE;
            stop = 1'b1;
          end
        end

        if (!stop) byte_offset_next = off_inc(byte_offset_next);
      end

      // end of text: close what is open, then report EOF
      if (!halted_next && (b == CH_NUL || stage_final)) begin
        case (scan_state_next)
          S_IDENT, S_INT, S_FLOAT: begin
            items[n] = mk_res((scan_state_next == S_IDENT) ? KIND_IDENT :
                              (scan_state_next == S_INT) ? KIND_INT : KIND_FLOAT,
                              ERR_NONE, 8'd0, tok_start_next, tok_length_next,
                              cur_line_next, tok_column_next, 1'b0);
            n = n + 2'd1;
          end
          S_DOT: begin
            items[n] = mk_res(KIND_INT, ERR_NONE, 8'd0, tok_start_next,
                              tok_length_next, cur_line_next, tok_column_next, 1'b0);
            n = n + 2'd1;
            items[n] = mk_res(KIND_EOF, ERR_UNKNOWN, CH_DOT,
                              off_add_len(tok_start_next, tok_length_next), '0,
                              cur_line_next, col_add_len(tok_column_next, tok_length_next),
                              1'b1);
            n = n + 2'd1;
            halted_next = 1'b1;
          end
          S_QMARK, S_STRING: begin
            items[n] = mk_res(KIND_EOF, (scan_state_next == S_QMARK) ? ERR_BOOL : ERR_STRING,
                              8'd0, tok_start_next, '0, tok_line_next, tok_column_next, 1'b1);
            n = n + 2'd1;
            halted_next = 1'b1;
          end
          default: ;
        endcase
        if (!halted_next) begin
          items[n] = mk_res(KIND_EOF, ERR_NONE, 8'd0, byte_offset_next, '0,
                            cur_line_next, cur_column_next, 1'b1);
          n = n + 2'd1;
        end
        halted_next     = 1'b1;
        scan_state_next = S_IDLE;
      end
    end

    // a final byte always returns the scanner to its reset state
    if (advance && stage_final) begin
      scan_state_next  = S_IDLE;
      halted_next      = 1'b0;
      byte_offset_next = '0;
      cur_line_next    = '0 + 1'b1;
      cur_column_next  = '0 + 1'b1;
      tok_start_next   = '0;
      tok_length_next  = '0;
      tok_line_next    = '0 + 1'b1;
      tok_column_next  = '0 + 1'b1;
    end

    push.count = n;
    push.item  = items;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      scan_state  <= S_IDLE;
      halted      <= 1'b0;
      byte_offset <= '0;
      cur_line    <= '0 + 1'b1;
      cur_column  <= '0 + 1'b1;
      tok_start   <= '0;
      tok_length  <= '0;
      tok_line    <= '0 + 1'b1;
      tok_column  <= '0 + 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      scan_state  <= scan_state_next;
      halted      <= halted_next;
      byte_offset <= byte_offset_next;
      cur_line    <= cur_line_next;
      cur_column  <= cur_column_next;
      tok_start   <= tok_start_next;
      tok_length  <= tok_length_next;
      tok_line    <= tok_line_next;
      tok_column  <= tok_column_next;
    end
  end

  // hold the request byte until the step can take it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte  <= text_byte;
      stage_final <= final_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !advance |-> push.count == 2'd0)
    else $error("results pushed without a scanner step");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    advance && halted |-> push.count == 2'd0)
    else $error("halted scanner produced a result");

  a_three_ends_stream: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd3 |-> push.item[2].last && push.item[2].kind == KIND_EOF)
    else $error("third result of a step does not end the stream");
`endif

endmodule

[src/ctt_result_fifo.sv]
// ----------------------------------------------------------------------------
// ctt_result_fifo: result queue
// Eight-entry queue that takes up to three results per cycle from the
// scanner and presents one result per cycle on the output channel while it is ready.
// ----------------------------------------------------------------------------
module ctt_result_fifo
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctt_push_t   push,
  output logic        space_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output ctt_result_t head
);

  localparam int DEPTH    = 8;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  ctt_result_t         mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];
  // room for the largest burst a single step can produce
  assign space_ok  = (count <= CNT_BITS'(DEPTH - MAX_RESULTS));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push.count) begin
        mem[wr_ptr + PTR_BITS'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= CNT_BITS'(DEPTH - MAX_RESULTS))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("result queue count out of range");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd0 && !pop |=> count == $past(count))
    else $error("result queue count moved with no push or pop");
`endif

endmodule

[sim/ctt_token_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctt_token_checker: token predictor and scoreboard for config_text_tokenizer
// Watches the byte and token channels. Every accepted byte runs through a
// bit-accurate scanner model, and the tokens it yields are queued. Every
// accepted token is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module ctt_token_checker
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  token_kind,
  input  logic [1:0]  error_code,
  input  logic [7:0]  bad_char,
  input  logic [23:0] start_offset,
  input  logic [15:0] token_length,
  input  logic [19:0] line_number,
  input  logic [15:0] column_number,
  input  logic        stream_end,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [LENGTH_BITS-1:0] UNIT_LEN   = LENGTH_BITS'(1);
  localparam logic [LINE_BITS-1:0]   FIRST_LINE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] FIRST_COL  = COLUMN_BITS'(1);

  scan_state_t            lex_state;
  logic                   lex_halted;
  logic [OFFSET_BITS-1:0] at_offset;
  logic [LINE_BITS-1:0]   at_line;
  logic [COLUMN_BITS-1:0] at_column;
  logic [OFFSET_BITS-1:0] tok_first;
  logic [LENGTH_BITS-1:0] tok_len;
  logic [LINE_BITS-1:0]   tok_row;
  logic [COLUMN_BITS-1:0] tok_col;

  ctt_result_t expected_tokens[$];
  int          step_results;
  ctt_result_t seen;
  ctt_result_t want;

  function automatic logic [31:0] capped(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] ceiling);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ceiling}) ? ceiling : s[31:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_plus(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [LENGTH_BITS-1:0] l);
    return OFFSET_BITS'(capped(32'(a), 32'(l), 32'(OFF_MAX)));
  endfunction

  function automatic logic [LINE_BITS-1:0] line_plus(input logic [LINE_BITS-1:0] a);
    return LINE_BITS'(capped(32'(a), 32'd1, 32'(LINE_MAX)));
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_plus(input logic [COLUMN_BITS-1:0] a,
                                                       input logic [LENGTH_BITS-1:0] l);
    return COLUMN_BITS'(capped(32'(a), 32'(l), 32'(COL_MAX)));
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_plus(input logic [LENGTH_BITS-1:0] a,
                                                       input logic [1:0] d);
    return LENGTH_BITS'(capped(32'(a), 32'(d), 32'(LEN_MAX)));
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic word_start(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic [3:0] brace_kind(input logic [7:0] c);
    case (c)
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_LBRACE: return KIND_LBRACE;
      default:   return KIND_RBRACE;
    endcase
  endfunction

  task automatic clear_scanner();
    lex_state  = S_IDLE;
    lex_halted = 1'b0;
    at_offset  = '0;
    at_line    = FIRST_LINE;
    at_column  = FIRST_COL;
    tok_first  = '0;
    tok_len    = '0;
    tok_row    = FIRST_LINE;
    tok_col    = FIRST_COL;
  endtask

  task automatic push_token(input logic [3:0] kind, input logic [1:0] err,
                            input logic [7:0] bad, input logic [OFFSET_BITS-1:0] start,
                            input logic [LENGTH_BITS-1:0] len,
                            input logic [LINE_BITS-1:0] line,
                            input logic [COLUMN_BITS-1:0] col, input logic last);
    ctt_result_t r;
    if (step_results >= MAX_RESULTS) return;
    r.kind  = kind;
    r.err   = err;
    r.bad   = bad;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.col   = col;
    r.last  = last;
    expected_tokens.push_back(r);
    step_results++;
  endtask

  task automatic close_token(input logic [3:0] kind);
    push_token(kind, ERR_NONE, 8'h00, tok_first, tok_len, at_line, tok_col, 1'b0);
    lex_state = S_IDLE;
  endtask

  task automatic stop_stream(input logic [1:0] code, input logic [7:0] bad,
                             input logic [OFFSET_BITS-1:0] start,
                             input logic [LINE_BITS-1:0] line,
                             input logic [COLUMN_BITS-1:0] col);
    push_token(KIND_EOF, code, bad, start, '0, line, col, 1'b1);
    lex_halted = 1'b1;
    lex_state  = S_IDLE;
  endtask

  // integer done, then the dot itself is the stray character
  task automatic dot_without_digit();
    close_token(KIND_INT);
    stop_stream(ERR_UNKNOWN, CH_DOT, off_plus(tok_first, tok_len), at_line,
                col_plus(tok_col, tok_len));
  endtask

  task automatic grow_token();
    tok_len   = len_plus(tok_len, 2'd1);
    at_column = col_plus(at_column, UNIT_LEN);
  endtask

  task automatic open_token(input scan_state_t s);
    lex_state = s;
    tok_first = at_offset;
    tok_len   = UNIT_LEN;
    tok_row   = at_line;
    tok_col   = at_column;
    at_column = col_plus(at_column, UNIT_LEN);
  endtask

  task automatic first_byte(input logic [7:0] b, output logic ok);
    ok = 1'b1;
    case (b)
      CH_SPACE, CH_TAB, CH_CR: at_column = col_plus(at_column, UNIT_LEN);
      CH_LF: begin
        at_line   = line_plus(at_line);
        at_column = FIRST_COL;
      end
      CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: begin
        push_token(brace_kind(b), ERR_NONE, 8'h00, at_offset, UNIT_LEN, at_line, at_column,
                   1'b0);
        at_column = col_plus(at_column, UNIT_LEN);
      end
      CH_QMARK: open_token(S_QMARK);
      CH_QUOTE: open_token(S_STRING);
      CH_HASH:  lex_state = S_COMMENT;
      default: begin
        if (dec_digit(b)) open_token(S_INT);
        else if (word_start(b)) open_token(S_IDENT);
        else begin
          stop_stream(ERR_UNKNOWN, b, at_offset, at_line, at_column);
          ok = 1'b0;
        end
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic restart;
    logic ok;
    restart = 1'b0;
    case (lex_state)
      S_IDENT: begin
        if (word_start(b) || dec_digit(b)) grow_token();
        else begin
          close_token(KIND_IDENT);
          restart = 1'b1;
        end
      end
      S_INT: begin
        if (dec_digit(b)) grow_token();
        else if (b == CH_DOT) begin
          lex_state = S_DOT;
          at_column = col_plus(at_column, UNIT_LEN);
        end else begin
          close_token(KIND_INT);
          restart = 1'b1;
        end
      end
      S_DOT: begin
        if (!dec_digit(b)) begin
          dot_without_digit();
          return;
        end
        tok_len   = len_plus(tok_len, 2'd2);
        at_column = col_plus(at_column, UNIT_LEN);
        lex_state = S_FLOAT;
      end
      S_FLOAT: begin
        if (dec_digit(b)) grow_token();
        else begin
          close_token(KIND_FLOAT);
          restart = 1'b1;
        end
      end
      S_QMARK: begin
        if (b == CH_SPACE) grow_token();
        else if (b == CH_Y || b == CH_N) begin
          grow_token();
          close_token(b == CH_Y ? KIND_TRUE : KIND_FALSE);
        end else begin
          stop_stream(ERR_BOOL, 8'h00, tok_first, tok_row, tok_col);
          return;
        end
      end
      S_STRING: begin
        grow_token();
        if (b == CH_QUOTE) close_token(KIND_STRING);
        else if (b == CH_LF) at_line = line_plus(at_line);
      end
      S_COMMENT: begin
        if (b == CH_LF) begin
          at_line   = line_plus(at_line);
          at_column = FIRST_COL;
          lex_state = S_IDLE;
        end
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      lex_state = S_IDLE;
      first_byte(b, ok);
      if (!ok) return;
    end
    at_offset = off_plus(at_offset, UNIT_LEN);
  endtask

  task automatic end_text();
    case (lex_state)
      S_IDENT:  close_token(KIND_IDENT);
      S_INT:    close_token(KIND_INT);
      S_FLOAT:  close_token(KIND_FLOAT);
      S_DOT:    dot_without_digit();
      S_QMARK:  stop_stream(ERR_BOOL, 8'h00, tok_first, tok_row, tok_col);
      S_STRING: stop_stream(ERR_STRING, 8'h00, tok_first, tok_row, tok_col);
      default: ;
    endcase
    if (!lex_halted)
      push_token(KIND_EOF, ERR_NONE, 8'h00, at_offset, '0, at_line, at_column, 1'b1);
    lex_halted = 1'b1;
    lex_state  = S_IDLE;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic fin);
    step_results = 0;
    if (lex_halted) begin
      // drop everything until the closing byte of the text
      if (fin) clear_scanner();
      return;
    end
    if (b != CH_NUL) take_byte(b);
    if (!lex_halted && (b == CH_NUL || fin)) end_text();
    if (fin) clear_scanner();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scanner();
      expected_tokens.delete();
      mismatches <= 0;
    end else begin
      // check the token before queuing what this edge's request yields
      if (out_valid && out_ready) begin
        seen.kind  = token_kind;
        seen.err   = error_code;
        seen.bad   = bad_char;
        seen.start = start_offset;
        seen.len   = token_length;
        seen.line  = line_number;
        seen.col   = column_number;
        seen.last  = stream_end;
        if (expected_tokens.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected token, expected none, actual kind %0d err %0d bad %h",
                   $time, seen.kind, seen.err, seen.bad,
                   " start %0d len %0d line %0d col %0d end %0b",
                   seen.start, seen.len, seen.line, seen.col, seen.last);
        end else begin
          want = expected_tokens.pop_front();
          if (seen !== want) begin
            mismatches <= mismatches + 1;
            $display("%0t: token mismatch, expected kind %0d err %0d bad %h start %0d",
                     $time, want.kind, want.err, want.bad, want.start,
                     " len %0d line %0d col %0d end %0b",
                     want.len, want.line, want.col, want.last);
            $display("%0t:                 actual kind %0d err %0d bad %h start %0d",
                     $time, seen.kind, seen.err, seen.bad, seen.start,
                     " len %0d line %0d col %0d end %0b",
                     seen.len, seen.line, seen.col, seen.last);
          end
        end
      end
      if (in_valid && in_ready) scan_byte(text_byte, final_byte);
    end
    outstanding <= expected_tokens.size();
  end

endmodule

[sim/config_text_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_tb: stimulus and verdict for the text tokenizer
// Feeds short directed texts, then random texts that are mostly well formed
// with some broken endings, with random stalls on both channels. The checker
// scores every token.
// ----------------------------------------------------------------------------
module config_text_tokenizer_tb;
  import ctt_pkg::*;

  localparam int CYCLE_LIMIT  = 40000;
  localparam int RANDOM_BYTES = 80;
  localparam logic [7:0] DIGIT_0 = 8'h30;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte  = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [3:0]  token_kind;
  logic [1:0]  error_code;
  logic [7:0]  bad_char;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic [19:0] line_number;
  logic [15:0] column_number;
  logic        stream_end;

  int         mismatches;
  int         outstanding;
  logic [7:0] doc_bytes[$];
  logic       gaps_on    = 1'b0;
  int         stall_left = 0;
  int         cycles     = 0;
  int         random_sent;

  always #4 clk = ~clk;

  config_text_tokenizer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .error_code    (error_code),
    .bad_char      (bad_char),
    .start_offset  (start_offset),
    .token_length  (token_length),
    .line_number   (line_number),
    .column_number (column_number),
    .stream_end    (stream_end)
  );

  ctt_token_checker token_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .error_code    (error_code),
    .bad_char      (bad_char),
    .start_offset  (start_offset),
    .token_length  (token_length),
    .line_number   (line_number),
    .column_number (column_number),
    .stream_end    (stream_end),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // token side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] any_digit();
    logic [7:0] d;
    d = 8'($urandom_range(0, 9));
    return DIGIT_0 + d;
  endfunction

  function automatic logic [7:0] word_byte(input logic first);
    logic [7:0] v;
    v = first ? 8'($urandom_range(0, 52)) : 8'($urandom_range(0, 62));
    if (v < 26) return 8'h61 + v;
    if (v < 52) return 8'h41 + (v - 8'd26);
    if (v == 52) return CH_UNDER;
    return DIGIT_0 + (v - 8'd53);
  endfunction

  function automatic logic opens_token(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF ||
           b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_QMARK || b == CH_QUOTE || b == CH_HASH || b == CH_UNDER ||
           (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (opens_token(b));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endtask

  task automatic add_lexeme();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 3))
          0:       doc_bytes.push_back(CH_LBRACK);
          1:       doc_bytes.push_back(CH_RBRACK);
          2:       doc_bytes.push_back(CH_LBRACE);
          default: doc_bytes.push_back(CH_RBRACE);
        endcase
      end
      2, 3: begin
        doc_bytes.push_back(word_byte(1'b1));
        repeat ($urandom_range(0, 6)) doc_bytes.push_back(word_byte(1'b0));
      end
      4: repeat ($urandom_range(1, 4)) doc_bytes.push_back(any_digit());
      5: begin
        repeat ($urandom_range(1, 3)) doc_bytes.push_back(any_digit());
        doc_bytes.push_back(CH_DOT);
        repeat ($urandom_range(1, 3)) doc_bytes.push_back(any_digit());
      end
      6: begin
        doc_bytes.push_back(CH_QMARK);
        repeat ($urandom_range(0, 3)) doc_bytes.push_back(CH_SPACE);
        doc_bytes.push_back($urandom_range(0, 1) ? CH_Y : CH_N);
      end
      7: begin
        doc_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) b = CH_LF;
          else do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
          doc_bytes.push_back(b);
        end
        doc_bytes.push_back(CH_QUOTE);
      end
      8: begin
        doc_bytes.push_back(CH_HASH);
        repeat ($urandom_range(0, 5)) begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
          doc_bytes.push_back(b);
        end
        doc_bytes.push_back(CH_LF);
      end
      default: doc_bytes.push_back(blank_byte());
    endcase
    if ($urandom_range(0, 5) != 0) doc_bytes.push_back(blank_byte());
  endtask

  task automatic add_fault();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: doc_bytes.push_back(stray_byte());
      1: begin
        doc_bytes.push_back(CH_QMARK);
        repeat ($urandom_range(0, 2)) doc_bytes.push_back(CH_SPACE);
        do b = 8'($urandom_range(1, 255)); while (b == CH_SPACE || b == CH_Y || b == CH_N);
        doc_bytes.push_back(b);
      end
      2: begin
        repeat ($urandom_range(1, 3)) doc_bytes.push_back(any_digit());
        doc_bytes.push_back(CH_DOT);
        if ($urandom_range(0, 1)) begin
          do b = 8'($urandom_range(1, 255)); while (b >= 8'h30 && b <= 8'h39);
          doc_bytes.push_back(b);
        end
      end
      3: begin
        doc_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
          doc_bytes.push_back(b);
        end
      end
      default: begin
        doc_bytes.push_back(CH_QMARK);
        repeat ($urandom_range(0, 2)) doc_bytes.push_back(CH_SPACE);
      end
    endcase
  endtask

  task automatic build_random_doc();
    doc_bytes.delete();
    repeat ($urandom_range(1, 8)) add_lexeme();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: ;
      6: doc_bytes.push_back(CH_NUL);
      7: begin
        doc_bytes.push_back(CH_NUL);
        repeat ($urandom_range(1, 2)) doc_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        add_fault();
        if ($urandom_range(0, 1)) begin
          doc_bytes.push_back(CH_NUL);
          repeat ($urandom_range(0, 2)) doc_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    // hold the request until it is taken
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++)
      send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;

    doc_bytes.delete();
    add_text("[?  y]{x_9 3.25}");
    send_doc();
    // dot followed by a non-digit, then a closing byte that is ignored
    doc_bytes.delete();
    add_text("7.\nq");
    send_doc();
    // end of text inside a string
    doc_bytes.delete();
    add_text("\"s");
    doc_bytes.push_back(CH_NUL);
    doc_bytes.push_back(8'hFF);
    send_doc();
    doc_bytes.delete();
    doc_bytes.push_back(CH_HASH);
    doc_bytes.push_back(8'h80);
    doc_bytes.push_back(CH_LF);
    doc_bytes.push_back(8'h01);
    send_doc();
    doc_bytes.delete();
    add_text("?x");
    send_doc();
    drain();

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      build_random_doc();
      random_sent += doc_bytes.size();
      send_doc();
      if ($urandom_range(0, 4) == 0) drain();
    end

    gaps_on = 1'b0;
    repeat (3) begin
      build_random_doc();
      send_doc();
    end
    drain();
    repeat (20) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
src/ctt_pkg.sv
src/ctt_scanner.sv
src/ctt_result_fifo.sv
src/config_text_tokenizer.sv
sim/ctt_token_checker.sv
sim/config_text_tokenizer_tb.sv
